/* hw/rtl/u16lp_pkg.sv */
// Shared types, codes and lookup functions for the UTF-16 unit list parser.
// No dependencies; every other file of the block imports this package.
package u16lp_pkg;

  localparam int unsigned PrefixLen  = 19;
  localparam int unsigned PosWidth   = $clog2(PrefixLen + 1);
  localparam int unsigned EndianPos  = 15;
  localparam int unsigned UnitDigits = 4;
  localparam int unsigned CntWidth   = 3;
  localparam int unsigned UnitWidth  = 16;

  localparam logic [7:0] ChrZero    = 8'h30;
  localparam logic [7:0] ChrX       = 8'h78;
  localparam logic [7:0] ChrSpace   = 8'h20;
  localparam logic [7:0] ChrTab     = 8'h09;
  localparam logic [7:0] ChrComma   = 8'h2c;
  localparam logic [7:0] ChrClose   = 8'h5d;
  localparam logic [7:0] ChrBigSel  = 8'h62;

  typedef enum logic [2:0] {
    PH_START,
    PH_EXPECT_X,
    PH_DIGITS,
    PH_AFTER_UNIT,
    PH_AFTER_COMMA,
    PH_SPACES
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MATCH   = 2'd1,
    ST_BAD_RECORD = 2'd2,
    ST_BAD_UNITS  = 2'd3
  } status_e;

  // Prefix matcher view handed to the body parser.
  typedef struct packed {
    logic in_body;  // the whole prefix has been matched
    logic closes;   // the current byte completes the prefix
    logic endian;   // big-endian prefix seen
  } pfx_t;

  // One result beat.
  typedef struct packed {
    logic                 final_res;
    logic [UnitWidth-1:0] code_unit;
    logic                 big_endian;
    logic                 matched;
    logic [1:0]           status;
  } res_t;

  // Expected prefix byte at a position (little-endian spelling).
  function automatic logic [7:0] prefix_char(input logic [PosWidth-1:0] pos);
    logic [7:0] chr;
    case (pos)
      5'd0:    chr = 8'h63; // c
      5'd1:    chr = 8'h6f; // o
      5'd2:    chr = 8'h6e; // n
      5'd3:    chr = 8'h73; // s
      5'd4:    chr = 8'h74; // t
      5'd5:    chr = 8'h2e; // .
      5'd6:    chr = 8'h73; // s
      5'd7:    chr = 8'h74; // t
      5'd8:    chr = 8'h72; // r
      5'd9:    chr = 8'h20; // space
      5'd10:   chr = 8'h75; // u
      5'd11:   chr = 8'h74; // t
      5'd12:   chr = 8'h66; // f
      5'd13:   chr = 8'h31; // 1
      5'd14:   chr = 8'h36; // 6
      5'd15:   chr = 8'h6c; // l
      5'd16:   chr = 8'h65; // e
      5'd17:   chr = 8'h20; // space
      5'd18:   chr = 8'h5b; // [
      default: chr = 8'h00;
    endcase
    return chr;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] chr);
    logic [4:0] res;
    res = 5'd0;
    if (chr inside {[8'h30:8'h39]}) begin
      res = {1'b1, 4'(chr - 8'h30)};
    end else if (chr inside {[8'h61:8'h66]}) begin
      res = {1'b1, 4'(chr - 8'h57)};
    end else if (chr inside {[8'h41:8'h46]}) begin
      res = {1'b1, 4'(chr - 8'h37)};
    end
    return res;
  endfunction

endpackage

/* hw/rtl/u16lp_prefix.sv */
// Prefix matcher: walks the fixed record prefix and picks the byte order.
// Depends on u16lp_pkg.
module u16lp_prefix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_byte_i,
  input  logic              is_final_byte_i,
  output u16lp_pkg::pfx_t   pfx_o
);
  import u16lp_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic                mismatch_q, mismatch_d;
  logic                endian_q, endian_d;
  logic                in_body;
  logic                hit_le;
  logic                hit_be;

  assign in_body = (pos_q == PosWidth'(PrefixLen));
  assign hit_le  = (char_byte_i == prefix_char(pos_q));
  assign hit_be  = (pos_q == PosWidth'(EndianPos)) && (char_byte_i == ChrBigSel);

  always_comb begin
    pos_d      = pos_q;
    mismatch_d = mismatch_q;
    endian_d   = endian_q;
    if (!mismatch_q && !in_body) begin
      if (hit_le) begin
        pos_d = pos_q + PosWidth'(1);
        if (pos_q == PosWidth'(EndianPos)) begin
          endian_d = 1'b0;
        end
      end else if (hit_be) begin
        pos_d    = pos_q + PosWidth'(1);
        endian_d = 1'b1;
      end else begin
        mismatch_d = 1'b1;
      end
    end
  end

  assign pfx_o.in_body = in_body;
  assign pfx_o.closes  = !in_body && (pos_d == PosWidth'(PrefixLen));
  assign pfx_o.endian  = endian_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      mismatch_q <= 1'b0;
      endian_q   <= 1'b0;
    end else if (accept_i) begin
      if (is_final_byte_i) begin
        pos_q      <= '0;
        mismatch_q <= 1'b0;
        endian_q   <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        mismatch_q <= mismatch_d;
        endian_q   <= endian_d;
      end
    end
  end

endmodule

/* hw/rtl/u16lp_body.sv */
// Body parser: unit list state machine, hex accumulation and final status.
// Depends on u16lp_pkg and the prefix view from u16lp_prefix.
module u16lp_body (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_byte_i,
  input  logic              is_final_byte_i,
  input  logic              type_is_string_i,
  input  u16lp_pkg::pfx_t   pfx_i,
  output logic              res_valid_o,
  output u16lp_pkg::res_t   res_o
);
  import u16lp_pkg::*;

  phase_e               phase_q, phase_d;
  logic [UnitWidth-1:0] acc_q, acc_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 err_q, err_d;
  logic                 emit;
  logic [4:0]           hex;

  assign hex = hex_digit(char_byte_i);

  // Next state for a non-final body byte.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    emit    = 1'b0;
    if (pfx_i.in_body && !err_q) begin
      case (phase_q)
        PH_START: begin
          if (char_byte_i == ChrZero) phase_d = PH_EXPECT_X;
          else err_d = 1'b1;
        end
        PH_EXPECT_X: begin
          if (char_byte_i == ChrX) begin
            phase_d = PH_DIGITS;
            acc_d   = '0;
            cnt_d   = '0;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (hex[4]) begin
            acc_d = {acc_q[UnitWidth-5:0], hex[3:0]};
            cnt_d = cnt_q + CntWidth'(1);
            if (cnt_d >= CntWidth'(UnitDigits)) begin
              phase_d = PH_AFTER_UNIT;
              emit    = 1'b1;
            end
          end else begin
            err_d = 1'b1;
          end
        end
        PH_AFTER_UNIT: begin
          if (char_byte_i == ChrComma) phase_d = PH_AFTER_COMMA;
          else if (char_byte_i != ChrSpace && char_byte_i != ChrTab) err_d = 1'b1;
        end
        PH_AFTER_COMMA: begin
          if (char_byte_i == ChrSpace) phase_d = PH_SPACES;
          else err_d = 1'b1;
        end
        PH_SPACES: begin
          if (char_byte_i == ChrZero) phase_d = PH_EXPECT_X;
          else if (char_byte_i != ChrSpace) err_d = 1'b1;
        end
        default: err_d = 1'b1;
      endcase
    end
  end

  // Result beat for the current byte.
  always_comb begin
    res_valid_o     = accept_i && (is_final_byte_i || emit);
    res_o.final_res = is_final_byte_i;
    res_o.code_unit = '0;
    res_o.big_endian = pfx_i.endian;
    res_o.matched   = 1'b1;
    res_o.status    = ST_OK;
    if (is_final_byte_i) begin
      if (!pfx_i.in_body) begin
        res_o.matched    = pfx_i.closes;
        res_o.big_endian = pfx_i.closes && pfx_i.endian;
        res_o.status     = pfx_i.closes ? ST_BAD_RECORD : ST_NO_MATCH;
      end else if (!type_is_string_i || char_byte_i != ChrClose) begin
        res_o.status = ST_BAD_RECORD;
      end else if (err_q || (phase_q != PH_START && phase_q != PH_AFTER_UNIT)) begin
        res_o.status = ST_BAD_UNITS;
      end
    end else begin
      res_o.code_unit = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      acc_q   <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      if (is_final_byte_i) begin
        phase_q <= PH_START;
        acc_q   <= '0;
        cnt_q   <= '0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

/* hw/rtl/u16lp_out_buf.sv */
// Two-entry result buffer that decouples the output stall from the input side.
// Depends on u16lp_pkg for the result beat type.
module u16lp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u16lp_pkg::res_t   push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output u16lp_pkg::res_t   out_data_o
);
  import u16lp_pkg::*;

  res_t       slot_q [2];
  logic       rd_ptr_q;
  logic       wr_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) count_d = count_q + 2'd1;
    else if (!push_i && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop)    rd_ptr_q <= !rd_ptr_q;
    end
  end

endmodule

/* hw/rtl/utf16_unit_list_parser_top.sv */
// Top level of the UTF-16 unit list parser.
// Depends on u16lp_pkg, u16lp_prefix, u16lp_body and u16lp_out_buf.
//
// The parser takes a text record one byte per beat, with is_final_byte_i
// marking the last byte. The record must open with "const.str utf16le [" or
// "const.str utf16be ["; the body is a list of units written "0x" plus exactly
// four hex digits, separated by optional blanks, a comma and at least one
// space. Each unit leaves as a beat with final_res_o low as soon as its fourth
// digit arrives. The last byte always yields one status beat (final_res_o
// high): ok, not matched, bad record (type not string or no
// closing bracket), or bad units. On any status other than ok the consumer
// must drop the units already delivered for that record. Every input byte is
// handled in the cycle it is accepted, so one byte can be taken each clock;
// at most one beat comes out per byte. Results pass through a two-entry
// buffer, so input keeps flowing while one finished beat waits; in_stall_o
// rises only when both buffer entries are occupied. The parser returns to its
// reset state after each record, so records follow each other directly.
module utf16_unit_list_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        is_final_byte_i,
  input  logic        type_is_string_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        final_res_o,
  output logic [15:0] code_unit_o,
  output logic        big_endian_o,
  output logic        matched_o,
  output logic [1:0]  status_o
);
  import u16lp_pkg::*;

  logic accept;
  logic full;
  logic res_valid;
  pfx_t pfx;
  res_t res;
  res_t out_data;

  // A byte is taken whenever the result buffer has a free entry.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  u16lp_prefix u_prefix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .char_byte_i     (char_byte_i),
    .is_final_byte_i (is_final_byte_i),
    .pfx_o           (pfx)
  );

  u16lp_body u_body (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .char_byte_i      (char_byte_i),
    .is_final_byte_i  (is_final_byte_i),
    .type_is_string_i (type_is_string_i),
    .pfx_i            (pfx),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  u16lp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign final_res_o  = out_data.final_res;
  assign code_unit_o  = out_data.code_unit;
  assign big_endian_o = out_data.big_endian;
  assign matched_o    = out_data.matched;
  assign status_o     = out_data.status;

endmodule
